// ===== rtl/efp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// efp_pkg
// shared types and codes for the escaped frame parser
// ----------------------------------------------------------------------------
package efp_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_START_CODE     = 3'd0;
    localparam logic [2:0] REG_END_CODE       = 3'd1;
    localparam logic [2:0] REG_ESCAPE_CODE    = 3'd2;
    localparam logic [2:0] REG_ESC_START_CODE = 3'd3;
    localparam logic [2:0] REG_ESC_END_CODE   = 3'd4;
    localparam logic [2:0] REG_ESC_ESC_CODE   = 3'd5;

    // token codes from front to back
    localparam logic [2:0] TOK_OPEN      = 3'd0;
    localparam logic [2:0] TOK_DATA      = 3'd1;
    localparam logic [2:0] TOK_BAD_ESC   = 3'd2;
    localparam logic [2:0] TOK_CLOSE     = 3'd3;
    localparam logic [2:0] TOK_CLOSE_ESC = 3'd4;
    localparam logic [2:0] TOK_STRAY     = 3'd5;

    // report status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_SUM   = 3'd1;
    localparam logic [2:0] ST_BAD_ESC   = 3'd2;
    localparam logic [2:0] ST_SHORT     = 3'd3;
    localparam logic [2:0] ST_STRAY     = 3'd4;
    localparam logic [2:0] ST_TOO_LONG  = 3'd5;

    // result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    localparam logic [7:0] MAX_PAYLOAD = 8'd255;

    // header slots
    localparam logic [2:0] HDR_FLAGS  = 3'd0;
    localparam logic [2:0] HDR_TARGET = 3'd1;
    localparam logic [2:0] HDR_SOURCE = 3'd2;
    localparam logic [2:0] HDR_ERROR  = 3'd6;
    localparam logic [2:0] HDR_DONE   = 3'd7;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
    } tok_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [2:0] status;
        logic [7:0] flag_bits;
        logic [7:0] target_id;
        logic [7:0] source_id;
        logic [7:0] device_id;
        logic [7:0] command_id;
        logic [7:0] sequence_number;
        logic [7:0] error_code;
        logic [7:0] payload_length;
    } res_t;

endpackage
`default_nettype wire

// ===== rtl/efp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// efp_front
// config registers, frame tracking and escape decoding into tokens
// ----------------------------------------------------------------------------
module efp_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [7:0]    cfg_data,
    input  wire logic          accept,
    input  wire logic [7:0]    rx_byte,
    output logic               tok_valid,
    output efp_pkg::tok_t      tok
);
    import efp_pkg::*;

    logic [7:0] start_code_reg, end_code_reg, escape_code_reg;
    logic [7:0] esc_start_reg, esc_end_reg, esc_esc_reg;
    logic       in_frame_reg, in_frame_next;
    logic       esc_pend_reg, esc_pend_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_code_reg  <= 8'd141;
            end_code_reg    <= 8'd216;
            escape_code_reg <= 8'd171;
            esc_start_reg   <= 8'd5;
            esc_end_reg     <= 8'd80;
            esc_esc_reg     <= 8'd35;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_START_CODE:     start_code_reg  <= cfg_data;
                REG_END_CODE:       end_code_reg    <= cfg_data;
                REG_ESCAPE_CODE:    escape_code_reg <= cfg_data;
                REG_ESC_START_CODE: esc_start_reg   <= cfg_data;
                REG_ESC_END_CODE:   esc_end_reg     <= cfg_data;
                REG_ESC_ESC_CODE:   esc_esc_reg     <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        in_frame_next = in_frame_reg;
        esc_pend_next = esc_pend_reg;
        tok_valid     = 1'b0;
        tok.kind      = TOK_DATA;
        tok.data      = rx_byte;
        if (rx_byte == start_code_reg)
        begin
            tok_valid     = 1'b1;
            tok.kind      = TOK_OPEN;
            in_frame_next = 1'b1;
            esc_pend_next = 1'b0;
        end
        else if (!in_frame_reg)
        begin
            tok_valid = 1'b1;
            tok.kind  = TOK_STRAY;
        end
        else if (rx_byte == end_code_reg)
        begin
            tok_valid     = 1'b1;
            tok.kind      = esc_pend_reg ? TOK_CLOSE_ESC : TOK_CLOSE;
            in_frame_next = 1'b0;
            esc_pend_next = 1'b0;
        end
        else if (esc_pend_reg)
        begin
            tok_valid     = 1'b1;
            esc_pend_next = 1'b0;
            if (rx_byte == esc_start_reg)
                tok.data = start_code_reg;
            else if (rx_byte == esc_end_reg)
                tok.data = end_code_reg;
            else if (rx_byte == esc_esc_reg)
                tok.data = escape_code_reg;
            else
                tok.kind = TOK_BAD_ESC;
        end
        else if (rx_byte == escape_code_reg)
        begin
            esc_pend_next = 1'b1;
        end
        else
        begin
            tok_valid = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            esc_pend_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_frame_reg <= in_frame_next;
            esc_pend_reg <= esc_pend_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/efp_tok_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// efp_tok_queue
// two-entry token queue between front and back
// ----------------------------------------------------------------------------
module efp_tok_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire efp_pkg::tok_t wr_tok,
    output logic               full,
    input  wire logic          rd_en,
    output efp_pkg::tok_t      rd_tok,
    output logic               empty
);
    import efp_pkg::*;

    tok_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full   = (count_reg == 2'd2);
    assign empty  = (count_reg == 2'd0);
    assign rd_tok = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_tok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (rd_en)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (wr_en && !rd_en)
                count_reg <= count_reg + 2'd1;
            else if (rd_en && !wr_en)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/efp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// efp_back
// frame state, checksum, header capture and result queue
// ----------------------------------------------------------------------------
module efp_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          tok_avail,
    input  wire efp_pkg::tok_t tok,
    output logic               tok_take,
    output efp_pkg::res_t      res_head,
    output logic               res_empty,
    input  wire logic          res_pop
);
    import efp_pkg::*;

    logic [7:0] held_reg, held_next;
    logic       held_valid_reg, held_valid_next;
    logic [7:0] sum_reg, sum_next;
    logic [2:0] hpos_reg, hpos_next;
    logic [7:0] fields_reg [7];
    logic       field_we;
    logic [7:0] count_reg, count_next;
    logic [2:0] fault_reg, fault_next;
    logic       clear_fields;

    res_t       res;
    logic       res_we;

    res_t       rq_reg [2];
    logic       rq_wr_reg, rq_rd_reg;
    logic [1:0] rq_cnt_reg;

    logic [7:0] flags_now;
    logic [2:0] slot;
    logic [2:0] close_fault;

    assign tok_take  = tok_avail && (rq_cnt_reg != 2'd2);
    assign res_empty = (rq_cnt_reg == 2'd0);
    assign res_head  = rq_reg[rq_rd_reg];

    // flags byte as seen after this write
    assign flags_now = (hpos_reg == HDR_FLAGS) ? held_reg : fields_reg[0];

    always_comb
    begin
        slot = hpos_reg + 3'd1;
        if (slot == HDR_TARGET && !flags_now[4])
            slot = slot + 3'd1;
        if (slot == HDR_SOURCE && !flags_now[5])
            slot = slot + 3'd1;
        if (slot == HDR_ERROR && !flags_now[0])
            slot = slot + 3'd1;
    end

    always_comb
    begin
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        sum_next        = sum_reg;
        hpos_next       = hpos_reg;
        count_next      = count_reg;
        fault_next      = fault_reg;
        field_we        = 1'b0;
        clear_fields    = 1'b0;
        res_we          = 1'b0;
        res             = '0;
        close_fault     = fault_reg;

        case (tok.kind)
            TOK_OPEN:
            begin
                held_next       = 8'd0;
                held_valid_next = 1'b0;
                sum_next        = 8'd0;
                hpos_next       = HDR_FLAGS;
                count_next      = 8'd0;
                fault_next      = ST_OK;
                clear_fields    = 1'b1;
            end
            TOK_STRAY:
            begin
                res_we     = 1'b1;
                res.kind   = KIND_REPORT;
                res.status = ST_STRAY;
            end
            TOK_CLOSE, TOK_CLOSE_ESC:
            begin
                if (tok.kind == TOK_CLOSE_ESC && fault_reg == ST_OK)
                    close_fault = ST_BAD_ESC;
                fault_next      = close_fault;
                res_we          = 1'b1;
                res.kind        = KIND_REPORT;
                if (close_fault != ST_OK)
                    res.status = close_fault;
                else if (hpos_reg != HDR_DONE || !held_valid_reg)
                    res.status = ST_SHORT;
                else if (held_reg != ~sum_reg)
                    res.status = ST_BAD_SUM;
                else
                    res.status = ST_OK;
                res.flag_bits       = fields_reg[0];
                res.target_id       = fields_reg[1];
                res.source_id       = fields_reg[2];
                res.device_id       = fields_reg[3];
                res.command_id      = fields_reg[4];
                res.sequence_number = fields_reg[5];
                res.error_code      = fields_reg[6];
                res.payload_length  = count_reg;
            end
            TOK_BAD_ESC:
            begin
                if (fault_reg == ST_OK)
                    fault_next = ST_BAD_ESC;
            end
            TOK_DATA:
            begin
                if (fault_reg == ST_OK)
                begin
                    if (held_valid_reg)
                    begin
                        // confirm the held byte, it is not the checksum
                        sum_next = sum_reg + held_reg;
                        if (hpos_reg != HDR_DONE)
                        begin
                            field_we  = 1'b1;
                            hpos_next = slot;
                        end
                        else if (count_reg >= MAX_PAYLOAD)
                        begin
                            fault_next = ST_TOO_LONG;
                        end
                        else
                        begin
                            count_next    = count_reg + 8'd1;
                            res_we        = 1'b1;
                            res.kind      = KIND_PAYLOAD;
                            res.data_byte = held_reg;
                        end
                    end
                    held_next       = tok.data;
                    held_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg       <= 8'd0;
            held_valid_reg <= 1'b0;
            sum_reg        <= 8'd0;
            hpos_reg       <= HDR_FLAGS;
            count_reg      <= 8'd0;
            fault_reg      <= ST_OK;
            for (int i = 0; i < 7; i++)
                fields_reg[i] <= 8'd0;
        end
        else if (tok_take)
        begin
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            sum_reg        <= sum_next;
            hpos_reg       <= hpos_next;
            count_reg      <= count_next;
            fault_reg      <= fault_next;
            if (clear_fields)
            begin
                for (int i = 0; i < 7; i++)
                    fields_reg[i] <= 8'd0;
            end
            else if (field_we)
            begin
                fields_reg[hpos_reg] <= held_reg;
            end
        end
    end

    // result queue
    always_ff @(posedge clk)
    begin
        if (tok_take && res_we)
            rq_reg[rq_wr_reg] <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rq_wr_reg  <= 1'b0;
            rq_rd_reg  <= 1'b0;
            rq_cnt_reg <= 2'd0;
        end
        else
        begin
            if (tok_take && res_we)
                rq_wr_reg <= ~rq_wr_reg;
            if (res_pop && !res_empty)
                rq_rd_reg <= ~rq_rd_reg;
            if ((tok_take && res_we) && !(res_pop && !res_empty))
                rq_cnt_reg <= rq_cnt_reg + 2'd1;
            else if (!(tok_take && res_we) && (res_pop && !res_empty))
                rq_cnt_reg <= rq_cnt_reg - 2'd1;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/escaped_frame_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// escaped_frame_parser
// streaming deframer for byte-stuffed frames with checksum check
// ----------------------------------------------------------------------------
// usage
//   input side is a queue: a byte beat is taken when push is high and full low
//   result side is a queue: the oldest result sits on the ports while empty
//   is low and leaves on a clock edge with pop high
//   config writes go through cfg_valid/cfg_ready (ready is always high),
//   cfg_index picks the code register, write only while the block is idle
// timing
//   one byte per cycle sustained while full is low; the front decodes a byte
//   into a token on the edge that takes it, the back engine consumes that
//   token from the two-entry token queue and writes its result into the
//   result queue, whose oldest entry sits on the ports until popped
//   a payload byte comes out only once the next data byte shows it is not
//   the checksum; the back takes one token per cycle while its queue has room
// stalls and reset
//   when pop stays low the two-entry result queue fills, the back engine
//   holds, the token queue fills and full goes high; nothing is dropped
//   reset clears both queues, leaves the parser outside a frame and loads
//   the default codes
// ----------------------------------------------------------------------------
module escaped_frame_parser (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // byte input
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] rx_byte,
    // results
    output logic            empty,
    input  wire logic       pop,
    output logic            kind,
    output logic [7:0]      data_byte,
    output logic [2:0]      status,
    output logic [7:0]      flag_bits,
    output logic [7:0]      target_id,
    output logic [7:0]      source_id,
    output logic [7:0]      device_id,
    output logic [7:0]      command_id,
    output logic [7:0]      sequence_number,
    output logic [7:0]      error_code,
    output logic [7:0]      payload_length,
    // configuration
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [2:0] cfg_index,
    input  wire logic [7:0] cfg_data
);
    import efp_pkg::*;

    logic accept;
    logic front_valid;
    tok_t front_tok;
    tok_t back_tok;
    logic tq_empty;
    logic tok_take;
    res_t head;

    // a beat is taken whenever the token queue has room
    assign accept = push && !full;

    efp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .tok_valid (front_valid),
        .tok       (front_tok)
    );

    // escape first bytes produce no token
    efp_tok_queue u_tok_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (accept && front_valid),
        .wr_tok (front_tok),
        .full   (full),
        .rd_en  (tok_take),
        .rd_tok (back_tok),
        .empty  (tq_empty)
    );

    efp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_avail (!tq_empty),
        .tok       (back_tok),
        .tok_take  (tok_take),
        .res_head  (head),
        .res_empty (empty),
        .res_pop   (pop)
    );

    // head of the result queue straight onto the ports
    assign kind            = head.kind;
    assign data_byte       = head.data_byte;
    assign status          = head.status;
    assign flag_bits       = head.flag_bits;
    assign target_id       = head.target_id;
    assign source_id       = head.source_id;
    assign device_id       = head.device_id;
    assign command_id      = head.command_id;
    assign sequence_number = head.sequence_number;
    assign error_code      = head.error_code;
    assign payload_length  = head.payload_length;

endmodule
`default_nettype wire
